@@ rtl/ext2glp_pkg.sv @@
// shared types, constants and the sparse group table for the layout planner
// no dependencies
package ext2glp_pkg;

    localparam int BLOCK_BYTES      = 1024;
    localparam int BLOCK_SHIFT      = 10;
    localparam int DESCRIPTOR_BYTES = 32;
    localparam int FIRST_BLOCK      = 1;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_BLOCKS   = 3'd0,
        REG_BPG          = 3'd1,
        REG_BPI          = 3'd2,
        REG_MIN_INODES   = 3'd3,
        REG_ROOT_BLOCKS  = 3'd4,
        REG_INODE_BYTES  = 3'd5,
        REG_MAX_ITER     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SMALL = 2'd1,
        ST_MANY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_NG  = 2'd0,
        DIV_INO = 2'd1,
        DIV_IPG = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        MUL_TOT  = 2'd0,
        MUL_TAB  = 2'd1,
        MUL_LAST = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT_NG,
        S_TEST_NG,
        S_WAIT_INO,
        S_START_IPG,
        S_WAIT_IPG,
        S_MUL_TOT,
        S_MUL_TAB,
        S_MUL_LAST,
        S_EVAL,
        S_DECIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_ng;
        logic     ld_ino;
        logic     ld_ipg;
        logic     ld_mul;
        mul_sel_t mul_sel;
        logic     ld_eval;
        logic     next_pass;
        logic     set_status;
        status_t  status_val;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic iter_done;
        logic tb_lt_min;
        logic div_done;
        logic ng_gt_limit;
        logic fits;
        logic ng_le1;
        logic out_free;
    } sts_t;

    localparam logic [31:0] POW3 [20] = '{
        32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187, 32'd6561,
        32'd19683, 32'd59049, 32'd177147, 32'd531441, 32'd1594323, 32'd4782969,
        32'd14348907, 32'd43046721, 32'd129140163, 32'd387420489,
        32'd1162261467, 32'd3486784401
    };
    localparam logic [31:0] POW5 [13] = '{
        32'd5, 32'd25, 32'd125, 32'd625, 32'd3125, 32'd15625, 32'd78125,
        32'd390625, 32'd1953125, 32'd9765625, 32'd48828125, 32'd244140625,
        32'd1220703125
    };
    localparam logic [31:0] POW7 [11] = '{
        32'd7, 32'd49, 32'd343, 32'd2401, 32'd16807, 32'd117649, 32'd823543,
        32'd5764801, 32'd40353607, 32'd282475249, 32'd1977326743
    };

    // groups 0, 1 and powers of 3, 5, 7 hold a superblock copy
    function automatic logic carries_super(input logic [31:0] g);
        logic hit;
        hit = (g <= 32'd1);
        for (int i = 0; i < 20; i++)
        begin
            hit = hit | (g == POW3[i]);
        end
        for (int i = 0; i < 13; i++)
        begin
            hit = hit | (g == POW5[i]);
        end
        for (int i = 0; i < 11; i++)
        begin
            hit = hit | (g == POW7[i]);
        end
        return hit;
    endfunction

endpackage

@@ rtl/ext2glp_if.sv @@
// request and result channel interfaces of the layout planner
// no dependencies
interface ext2glp_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] sector_count;
    logic [18:0] group_limit;

    modport source (output valid, output sector_count, output group_limit, input ready);
    modport sink (input valid, input sector_count, input group_limit, output ready);
endinterface

interface ext2glp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [30:0] block_total;
    logic [31:0] group_count;
    logic [31:0] inodes_each_group;
    logic [31:0] inode_total;
    logic [31:0] inode_table_blocks;
    logic [31:0] descriptor_blocks;
    logic [31:0] last_group_size;
    logic [31:0] last_group_overhead;

    modport source (output valid, output status, output block_total, output group_count,
        output inodes_each_group, output inode_total, output inode_table_blocks,
        output descriptor_blocks, output last_group_size, output last_group_overhead,
        input ready);
    modport sink (input valid, input status, input block_total, input group_count,
        input inodes_each_group, input inode_total, input inode_table_blocks,
        input descriptor_blocks, input last_group_size, input last_group_overhead,
        output ready);
endinterface

@@ rtl/ext2glp_div.sv @@
// 32-bit unsigned restoring divider, one quotient bit per cycle
// no dependencies
module ext2glp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] rtmp;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rtmp      = {r_reg, q_reg[31]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = 32'd0;
            d_next    = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rtmp >= {1'b0, d_reg})
            begin
                r_next = 32'(rtmp - {1'b0, d_reg});
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = rtmp[31:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

@@ rtl/ext2glp_dp.sv @@
// datapath: configuration registers, layout registers, shared divider and multiplier
// depends on ext2glp_pkg, ext2glp_if and ext2glp_div
module ext2glp_dp
    import ext2glp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    ext2glp_req_if.sink            in_ch,
    ext2glp_rsp_if.source          out_ch
);
    logic [31:0] min_blocks_reg;
    logic [16:0] bpg_reg, bpi_reg, min_inodes_reg;
    logic [7:0]  root_reg, max_iter_reg;
    logic [12:0] isz_reg;

    logic [31:0] tb_reg, ng_reg, ino_reg, ipg_reg, itot_reg, itab_reg;
    logic [31:0] gdt_reg, plast_reg, lsize_reg, lneed_reg;
    logic [18:0] limit_reg;
    logic [7:0]  iter_reg;
    status_t     status_reg;

    logic        out_valid_reg;
    logic [1:0]  o_status_reg;
    logic [30:0] o_tb_reg;
    logic [31:0] o_ng_reg, o_ipg_reg, o_itot_reg, o_itab_reg, o_gdt_reg;
    logic [31:0] o_lsize_reg, o_lneed_reg;

    logic [31:0] bpg, bpi, isz;
    logic [31:0] div_a, div_b, quot;
    logic        div_done;
    logic [31:0] mul_a, mul_b, prod;
    logic [63:0] prod_full;
    logic [31:0] tab_sum;
    logic [31:0] last, dprod, gsum, gdt_val, lneed_val;
    logic        ok;

    assign bpg = (bpg_reg == 17'd0) ? 32'd1 : {15'd0, bpg_reg};
    assign bpi = (bpi_reg == 17'd0) ? 32'd1 : {15'd0, bpi_reg};
    assign isz = (isz_reg == 13'd0) ? 32'd1 : {19'd0, isz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_blocks_reg <= 32'd64;
            bpg_reg        <= 17'd8192;
            bpi_reg        <= 17'd4;
            min_inodes_reg <= 17'd16;
            root_reg       <= 8'd1;
            isz_reg        <= 13'd128;
            max_iter_reg   <= 8'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_BLOCKS:  min_blocks_reg <= cfg_wdata;
                REG_BPG:         bpg_reg        <= cfg_wdata[16:0];
                REG_BPI:         bpi_reg        <= cfg_wdata[16:0];
                REG_MIN_INODES:  min_inodes_reg <= cfg_wdata[16:0];
                REG_ROOT_BLOCKS: root_reg       <= cfg_wdata[7:0];
                REG_INODE_BYTES: isz_reg        <= cfg_wdata[12:0];
                REG_MAX_ITER:    max_iter_reg   <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_NG:
            begin
                div_a = tb_reg - 32'(FIRST_BLOCK) + bpg - 32'd1;
                div_b = bpg;
            end
            DIV_INO:
            begin
                div_a = tb_reg;
                div_b = bpi;
            end
            default:
            begin
                div_a = ino_reg + ng_reg - 32'd1;
                div_b = ng_reg;
            end
        endcase
    end

    ext2glp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_TOT:
            begin
                mul_a = ipg_reg;
                mul_b = ng_reg;
            end
            MUL_TAB:
            begin
                mul_a = ipg_reg;
                mul_b = isz;
            end
            default:
            begin
                mul_a = ng_reg - 32'd1;
                mul_b = bpg;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod      = prod_full[31:0];
    assign tab_sum   = prod + 32'(BLOCK_BYTES - 1);

    // last group metadata need
    assign last    = ng_reg - 32'd1;
    assign dprod   = 32'(ng_reg * 32'(DESCRIPTOR_BYTES));
    assign gsum    = dprod + 32'(BLOCK_BYTES - 1);
    assign gdt_val = gsum >> BLOCK_SHIFT;
    always_comb
    begin
        lneed_val = 32'd2 + itab_reg;
        if (carries_super(last))
        begin
            lneed_val = lneed_val + 32'd1 + gdt_val;
        end
        if (last == 32'd0)
        begin
            lneed_val = lneed_val + {24'd0, root_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tb_reg    <= {1'b0, in_ch.sector_count[31:1]};
            limit_reg <= in_ch.group_limit;
        end
        else if (cmd.next_pass)
        begin
            tb_reg <= 32'(FIRST_BLOCK) + plast_reg;
        end
        if (cmd.ld_ng)
        begin
            ng_reg <= (quot == 32'd0) ? 32'd1 : quot;
        end
        if (cmd.ld_ino)
        begin
            ino_reg <= (quot < {15'd0, min_inodes_reg}) ? {15'd0, min_inodes_reg} : quot;
        end
        if (cmd.ld_ipg)
        begin
            ipg_reg <= (quot + 32'd7) & ~32'd7;
        end
        if (cmd.ld_mul)
        begin
            case (cmd.mul_sel)
                MUL_TOT: itot_reg  <= prod;
                MUL_TAB: itab_reg  <= tab_sum >> BLOCK_SHIFT;
                default: plast_reg <= prod;
            endcase
        end
        if (cmd.ld_eval)
        begin
            gdt_reg   <= gdt_val;
            lsize_reg <= tb_reg - (32'(FIRST_BLOCK) + plast_reg);
            lneed_reg <= lneed_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg   <= 8'd0;
            status_reg <= ST_SMALL;
        end
        else
        begin
            if (cmd.load_in)
            begin
                iter_reg <= 8'd0;
            end
            else if (cmd.next_pass)
            begin
                iter_reg <= iter_reg + 8'd1;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_val;
            end
        end
    end

    assign ok = (status_reg == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_status_reg <= status_reg;
            o_tb_reg     <= ok ? tb_reg[30:0] : 31'd0;
            o_ng_reg     <= ok ? ng_reg : 32'd0;
            o_ipg_reg    <= ok ? ipg_reg : 32'd0;
            o_itot_reg   <= ok ? itot_reg : 32'd0;
            o_itab_reg   <= ok ? itab_reg : 32'd0;
            o_gdt_reg    <= ok ? gdt_reg : 32'd0;
            o_lsize_reg  <= ok ? lsize_reg : 32'd0;
            o_lneed_reg  <= ok ? lneed_reg : 32'd0;
        end
    end

    assign sts.iter_done   = (iter_reg >= max_iter_reg);
    assign sts.tb_lt_min   = (tb_reg < min_blocks_reg);
    assign sts.div_done    = div_done;
    assign sts.ng_gt_limit = (ng_reg > {13'd0, limit_reg});
    assign sts.fits        = (lsize_reg >= lneed_reg);
    assign sts.ng_le1      = (ng_reg <= 32'd1);
    assign sts.out_free    = !out_valid_reg || out_ch.ready;

    assign in_ch.ready                = cmd.load_in;
    assign out_ch.valid               = out_valid_reg;
    assign out_ch.status              = o_status_reg;
    assign out_ch.block_total         = o_tb_reg;
    assign out_ch.group_count         = o_ng_reg;
    assign out_ch.inodes_each_group   = o_ipg_reg;
    assign out_ch.inode_total         = o_itot_reg;
    assign out_ch.inode_table_blocks  = o_itab_reg;
    assign out_ch.descriptor_blocks   = o_gdt_reg;
    assign out_ch.last_group_size     = o_lsize_reg;
    assign out_ch.last_group_overhead = o_lneed_reg;

    a_ipg_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld_mul && cmd.mul_sel == MUL_TOT) |-> (ipg_reg[2:0] == 3'd0))
        else $error("inodes per group not a multiple of 8");
    a_ng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && cmd.div_sel == DIV_IPG) |-> (ng_reg != 32'd0))
        else $error("zero group count used as divisor");
    a_ok_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && status_reg == ST_OK) |-> (lsize_reg >= lneed_reg))
        else $error("ok result with short last group");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && status_reg != ST_OK) |=> (out_ch.group_count == 32'd0))
        else $error("error result carries nonzero fields");
endmodule

@@ rtl/ext2glp_ctrl.sv @@
// controller state machine sequencing one layout request
// depends on ext2glp_pkg
module ext2glp_ctrl
    import ext2glp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.iter_done || sts.tb_lt_min)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_WAIT_NG;
                end
            end
            S_WAIT_NG:   if (sts.div_done) state_next = S_TEST_NG;
            S_TEST_NG:   state_next = sts.ng_gt_limit ? S_FINISH : S_WAIT_INO;
            S_WAIT_INO:  if (sts.div_done) state_next = S_START_IPG;
            S_START_IPG: state_next = S_WAIT_IPG;
            S_WAIT_IPG:  if (sts.div_done) state_next = S_MUL_TOT;
            S_MUL_TOT:   state_next = S_MUL_TAB;
            S_MUL_TAB:   state_next = S_MUL_LAST;
            S_MUL_LAST:  state_next = S_EVAL;
            S_EVAL:      state_next = S_DECIDE;
            S_DECIDE:    state_next = (sts.fits || sts.ng_le1) ? S_FINISH : S_CHECK;
            S_FINISH:    if (sts.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_sel    = DIV_NG;
        cmd.mul_sel    = MUL_TOT;
        cmd.status_val = ST_SMALL;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = 1'b1;
            end
            S_CHECK:
            begin
                if (sts.iter_done || sts.tb_lt_min)
                begin
                    cmd.set_status = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_WAIT_NG:
            begin
                cmd.ld_ng = sts.div_done;
            end
            S_TEST_NG:
            begin
                cmd.div_sel = DIV_INO;
                if (sts.ng_gt_limit)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_MANY;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_WAIT_INO:
            begin
                cmd.ld_ino = sts.div_done;
            end
            S_START_IPG:
            begin
                cmd.div_sel   = DIV_IPG;
                cmd.div_start = 1'b1;
            end
            S_WAIT_IPG:
            begin
                cmd.ld_ipg = sts.div_done;
            end
            S_MUL_TOT:
            begin
                cmd.ld_mul = 1'b1;
            end
            S_MUL_TAB:
            begin
                cmd.ld_mul  = 1'b1;
                cmd.mul_sel = MUL_TAB;
            end
            S_MUL_LAST:
            begin
                cmd.ld_mul  = 1'b1;
                cmd.mul_sel = MUL_LAST;
            end
            S_EVAL:
            begin
                cmd.ld_eval = 1'b1;
            end
            S_DECIDE:
            begin
                if (sts.fits)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_OK;
                end
                else if (sts.ng_le1)
                begin
                    cmd.set_status = 1'b1;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default: ;
        endcase
    end

    a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.div_start)
        else $error("divider restarted while busy");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_in && in_valid) |=> (state_reg == S_CHECK))
        else $error("accepted transaction not started");
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == S_IDLE))
        else $error("result loaded outside finish");
endmodule

@@ rtl/ext2_group_layout_planner.sv @@
// A request is accepted, worked in layout passes, and its result is then loaded. Each
// full pass runs three 32-bit divisions through one shared divider at one quotient bit
// per cycle, then three multiply steps and two evaluation steps. A pass that stops on
// the size check or the group limit is shorter. A request makes up to max_iterations
// passes. One request is worked at a time. The next is accepted once the result is
// loaded into the output register, while that result may still wait.
// top level: joins ext2glp_ctrl and ext2glp_dp; depends on ext2glp_pkg, ext2glp_if
module ext2_group_layout_planner
    import ext2glp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ext2glp_req_if.sink            in_ch,
    ext2glp_rsp_if.source          out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);
    cmd_t cmd;
    sts_t sts;

    ext2glp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    ext2glp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );
endmodule

@@ tb/sv/ext2_group_layout_planner_tb.sv @@
// testbench for the ext2 group layout planner: directed and random layout requests,
// checked against a behavioral layout calculator held in a small scoreboard class
// depends on ext2glp_pkg, ext2glp_if and the planner rtl
`timescale 1ns / 100ps

module ext2_group_layout_planner_tb;
    import ext2glp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] block_total;
        logic [31:0] group_count;
        logic [31:0] inodes_each_group;
        logic [31:0] inode_total;
        logic [31:0] inode_table_blocks;
        logic [31:0] descriptor_blocks;
        logic [31:0] last_group_size;
        logic [31:0] last_group_overhead;
    } layout_t;

    class layout_scoreboard;
        bit [31:0] min_blocks;
        bit [31:0] bpg;
        bit [31:0] bpi;
        bit [31:0] min_inodes;
        bit [31:0] root_blocks;
        bit [31:0] inode_bytes;
        bit [31:0] max_iter;
        layout_t   pending[$];
        int        mismatches;

        function void reset_regs();
            min_blocks  = 64;
            bpg         = 8192;
            bpi         = 4;
            min_inodes  = 16;
            root_blocks = 1;
            inode_bytes = 128;
            max_iter    = 8;
            mismatches  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [31:0] v);
            case (idx)
                REG_MIN_BLOCKS:  min_blocks  = v;
                REG_BPG:         bpg         = v & 32'h1ffff;
                REG_BPI:         bpi         = v & 32'h1ffff;
                REG_MIN_INODES:  min_inodes  = v & 32'h1ffff;
                REG_ROOT_BLOCKS: root_blocks = v & 32'hff;
                REG_INODE_BYTES: inode_bytes = v & 32'h1fff;
                REG_MAX_ITER:    max_iter    = v & 32'hff;
                default:         ;
            endcase
        endfunction

        function bit is_power(bit [31:0] n, longint unsigned b);
            longint unsigned v;
            v = b;
            while (v < n)
            begin
                v = v * b;
            end
            return v == n;
        endfunction

        function void note_request(bit [31:0] sectors, bit [18:0] limit);
            layout_t   r;
            bit [31:0] g, pi, isz, tb, ng, ipg, itot, itab, gdt, lsize, lneed, ino, last;
            status_t   st;
            g     = (bpg == 0) ? 1 : bpg;
            pi    = (bpi == 0) ? 1 : bpi;
            isz   = (inode_bytes == 0) ? 1 : inode_bytes;
            tb    = sectors / 2;
            st    = ST_SMALL;
            ng    = 0;
            ipg   = 0;
            itot  = 0;
            itab  = 0;
            gdt   = 0;
            lsize = 0;
            lneed = 0;
            for (int unsigned it = 0; it < max_iter; it++)
            begin
                if (tb < min_blocks)
                begin
                    st = ST_SMALL;
                    break;
                end
                ng = (tb - FIRST_BLOCK + g - 1) / g;
                if (ng == 0)
                    ng = 1;
                if (ng > {13'd0, limit})
                begin
                    st = ST_MANY;
                    break;
                end
                ino = tb / pi;
                if (ino < min_inodes)
                    ino = min_inodes;
                ipg   = (ino + ng - 1) / ng;
                ipg   = (ipg + 7) & 32'hfffffff8;
                itot  = ipg * ng;
                itab  = (ipg * isz + BLOCK_BYTES - 1) / BLOCK_BYTES;
                gdt   = (ng * DESCRIPTOR_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
                last  = ng - 1;
                lsize = tb - (FIRST_BLOCK + last * g);
                lneed = 2 + itab;
                if (last <= 1 || is_power(last, 3) || is_power(last, 5) || is_power(last, 7))
                    lneed = lneed + 1 + gdt;
                if (last == 0)
                    lneed = lneed + root_blocks;
                if (lsize >= lneed)
                begin
                    st = ST_OK;
                    break;
                end
                if (ng <= 1)
                begin
                    st = ST_SMALL;
                    break;
                end
                tb = FIRST_BLOCK + (ng - 1) * g;
                st = ST_SMALL;
            end
            r = '{default: '0};
            r.status = st;
            if (st == ST_OK)
            begin
                r.block_total         = tb[30:0];
                r.group_count         = ng;
                r.inodes_each_group   = ipg;
                r.inode_total         = itot;
                r.inode_table_blocks  = itab;
                r.descriptor_blocks   = gdt;
                r.last_group_size     = lsize;
                r.last_group_overhead = lneed;
            end
            pending.push_back(r);
        endfunction

        function void check_result(layout_t a);
            layout_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: status %0d", a.status);
                return;
            end
            e = pending.pop_front();
            if (a !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %p act %p", e, a);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    ext2glp_req_if in_ch();
    ext2glp_rsp_if out_ch();

    layout_scoreboard sb;
    bit               stall_on;
    bit               hold_long;
    int               idle_cycles;

    ext2_group_layout_planner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        sb = new();
        sb.reset_regs();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_MIN_BLOCKS;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.sector_count = '0;
        in_ch.group_limit  = '0;
        out_ch.ready       = 1'b0;
        stall_on           = 1'b1;
        hold_long          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: random stalls, long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.status, out_ch.block_total, out_ch.group_count,
                    out_ch.inodes_each_group, out_ch.inode_total, out_ch.inode_table_blocks,
                    out_ch.descriptor_blocks, out_ch.last_group_size,
                    out_ch.last_group_overhead});
            if (hold_long)
            begin
                out_ch.ready <= 1'b0;
                for (n = 0; n < 3000; n++)
                    @(posedge clk);
                hold_long = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 400000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_request(bit [31:0] sectors, bit [18:0] limit);
        if (stall_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sector_count <= sectors;
        in_ch.group_limit  <= limit;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(sectors, limit);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, bit [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic random_config();
        write_reg(REG_MIN_BLOCKS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200));
        write_reg(REG_BPG, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                    : $urandom_range(1, 64));
        write_reg(REG_BPI, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                    : $urandom_range(1, 16));
        write_reg(REG_MIN_INODES, $urandom_range(0, 131071));
        write_reg(REG_ROOT_BLOCKS, $urandom_range(0, 255));
        write_reg(REG_INODE_BYTES, $urandom_range(0, 8191));
        write_reg(REG_MAX_ITER, $urandom_range(0, 12));
    endtask

    function automatic bit [31:0] pick_sectors();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 600);
            2:       return $urandom_range(0, 20000);
            default: return $urandom_range(0, 4000000);
        endcase
    endfunction

    function automatic bit [18:0] pick_limit();
        case ($urandom_range(0, 2))
            0:       return 19'($urandom_range(0, 19'h7ffff));
            1:       return 19'($urandom_range(0, 8));
            default: return 19'($urandom_range(0, 5000));
        endcase
    endfunction

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        // directed: reset settings
        send_request(32'd0, 19'd0);
        send_request(32'hffffffff, 19'h7ffff);
        send_request(32'd128, 19'd1);
        send_request(32'd129, 19'd1);
        send_request(32'd16386, 19'd2);
        send_request(32'd16390, 19'd2);
        send_request(32'd16384 * 9 + 2, 19'd20);
        send_request(32'd1000000, 19'd1);
        send_request(32'hfffffffe, 19'd0);
        send_request(32'h80000000, 19'h40000);
        drain();
        // directed: zero registers and extremes
        write_reg(REG_MIN_BLOCKS, 32'd0);
        write_reg(REG_BPG, 32'd0);
        write_reg(REG_BPI, 32'd0);
        write_reg(REG_INODE_BYTES, 32'd0);
        write_reg(REG_MIN_INODES, 32'd0);
        write_reg(REG_ROOT_BLOCKS, 32'd255);
        write_reg(REG_MAX_ITER, 32'd0);
        send_request(32'd1000, 19'h7ffff);
        drain();
        write_reg(REG_MAX_ITER, 32'd255);
        send_request(32'd0, 19'h7ffff);
        send_request(32'd1, 19'h7ffff);
        send_request(32'd2, 19'd1);
        send_request(32'd60, 19'h7ffff);
        drain();
        write_reg(REG_BPG, 32'd65536);
        write_reg(REG_BPI, 32'd65536);
        write_reg(REG_MIN_INODES, 32'd65536);
        write_reg(REG_INODE_BYTES, 32'd4096);
        write_reg(REG_MIN_BLOCKS, 32'hffffffff);
        send_request(32'hffffffff, 19'h7ffff);
        drain();
        write_reg(REG_MIN_BLOCKS, 32'd10);
        write_reg(REG_BPG, 32'd8);
        write_reg(REG_INODE_BYTES, 32'd1);
        write_reg(REG_MIN_INODES, 32'd8);
        send_request(32'd2 * (8 * 243 + 1) + 60, 19'h7ffff);
        send_request(32'd2 * (8 * 625 + 1) + 30, 19'h7ffff);
        send_request(32'd2 * (8 * 2401 + 1) + 30, 19'h7ffff);
        drain();
        // long output hold-off so the block backs up
        hold_long = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(pick_sectors(), pick_limit());
        drain();
        // random phases
        for (int p = 0; p < 16; p++)
        begin
            random_config();
            if (p >= 14)
                stall_on = 1'b0;
            for (int i = 0; i < 50; i++)
                send_request(pick_sectors(), pick_limit());
            drain();
        end
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
